// ===== hdl/rdc_pkg.sv =====
package rdc_pkg;

    localparam int unsigned RADIX_W = 6;
    localparam int unsigned DIGIT_W = 6;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(8'h41);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_SHOW
    } t_state;

    typedef struct packed {
        logic load;
        logic cont;
    } t_div_ctrl;

    typedef struct packed {
        logic               done;
        logic               more;
        logic [DIGIT_W-1:0] digit;
    } t_div_stat;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DEC_DIGITS) begin
            c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
        end else begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ===== hdl/rdc_in_if.sv =====
interface rdc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== hdl/rdc_out_if.sv =====
interface rdc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== hdl/rdc_serial_div.sv =====
module rdc_serial_div
    import rdc_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_ctrl             i_ctrl,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [RADIX_W-1:0]    i_radix,
    output t_div_stat             o_stat
);

    localparam int unsigned BIT_W = $clog2(VALUE_BITS);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);

    logic                  r_run;
    logic [BIT_W-1:0]      r_bit;
    logic [VALUE_BITS-1:0] r_quot;
    logic [DIGIT_W-1:0]    r_rem;
    logic                  r_nz;

    logic [DIGIT_W:0]      w_trial;
    logic [DIGIT_W:0]      w_diff;
    logic                  w_ge;
    logic [VALUE_BITS-1:0] n_quot;
    logic [DIGIT_W-1:0]    n_rem;
    logic                  n_nz;
    logic                  w_last;

    // one restoring step per cycle, quotient bits enter at the bottom
    always_comb begin
        w_trial = {r_rem, r_quot[VALUE_BITS-1]};
        w_ge    = w_trial >= {1'b0, i_radix};
        w_diff  = w_trial - {1'b0, i_radix};
        n_rem   = w_ge ? w_diff[DIGIT_W-1:0] : w_trial[DIGIT_W-1:0];
        n_quot  = {r_quot[VALUE_BITS-2:0], w_ge};
        n_nz    = r_nz | w_ge;
        w_last  = r_run && (r_bit == BIT_LAST);
    end

    assign o_stat.done  = w_last;
    assign o_stat.more  = n_nz;
    assign o_stat.digit = n_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_ctrl.load || i_ctrl.cont) begin
            r_run <= 1'b1;
        end else if (w_last) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_quot <= i_value;
            r_bit  <= '0;
            r_rem  <= '0;
            r_nz   <= 1'b0;
        end else if (i_ctrl.cont) begin
            r_quot <= n_quot;
            r_bit  <= '0;
            r_rem  <= '0;
            r_nz   <= 1'b0;
        end else if (r_run) begin
            r_quot <= n_quot;
            r_bit  <= r_bit + BIT_W'(1);
            r_rem  <= n_rem;
            r_nz   <= n_nz;
        end
    end

endmodule

// ===== hdl/radix_digit_converter_core.sv =====
// operation: bit-serial division produces one digit at a time, each digit is
// written to the digit store, then the digits are read back from the store and presented
// throughput: one value at a time, up to MAX_DIGITS digits per value,
// with VALUE_BITS = MAX_DIGITS = 64 by default
// reset: synchronous active low, radix returns to 10, control goes idle,
// the digit store is not cleared
module radix_digit_converter_core
    import rdc_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned MAX_DIGITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [RADIX_W-1:0] i_cfg_wdata,
    rdc_in_if.sink             i_in,
    rdc_out_if.source          o_out
);

    localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIGITS - 1);

    t_state               r_state;
    t_state               n_state;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     n_idx;
    logic [RADIX_W-1:0]   r_radix;
    logic [RADIX_W-1:0]   n_radix;
    logic [DIGIT_W-1:0]   r_store [MAX_DIGITS];
    logic [DIGIT_W-1:0]   r_rd_data;

    t_div_ctrl w_div_ctrl;
    t_div_stat w_div_stat;
    logic      w_out_xfer;

    rdc_serial_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .i_value (i_in.value[VALUE_BITS-1:0]),
        .i_radix (r_radix),
        .o_stat  (w_div_stat)
    );

    // radix saturates to the legal range on write
    always_comb begin
        if (i_cfg_wdata < RADIX_MIN) begin
            n_radix = RADIX_MIN;
        end else if (i_cfg_wdata > RADIX_MAX) begin
            n_radix = RADIX_MAX;
        end else begin
            n_radix = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= n_radix;
        end
    end

    assign w_out_xfer = o_out.valid && o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_stat.done && !(w_div_stat.more && r_idx != IDX_LAST)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (w_out_xfer) begin
                    n_state = (r_idx == '0) ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready      = 1'b0;
        o_out.valid     = 1'b0;
        w_div_ctrl.load = 1'b0;
        w_div_ctrl.cont = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready      = 1'b1;
                w_div_ctrl.load = i_in.valid;
            end
            ST_DIV: begin
                w_div_ctrl.cont = w_div_stat.done && w_div_stat.more && (r_idx != IDX_LAST);
            end
            ST_SHOW: begin
                o_out.valid = 1'b1;
            end
            default: begin
                o_out.valid = 1'b0;
            end
        endcase
    end

    // digit index counts up while dividing, then back down while emitting
    always_comb begin
        n_idx = r_idx;
        if (w_div_ctrl.load) begin
            n_idx = '0;
        end else if (w_div_ctrl.cont) begin
            n_idx = r_idx + IDX_W'(1);
        end else if (w_out_xfer && r_idx != '0) begin
            n_idx = r_idx - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && w_div_stat.done) begin
            r_store[r_idx] <= w_div_stat.digit;
        end
        r_rd_data <= r_store[r_idx];
    end

    assign o_out.digit_char = to_ascii(r_rd_data);
    assign o_out.last_digit = (r_idx == '0);

    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_DIV))
        else $error("input transfer did not start a division");

    a_done_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out.last_digit) |=> (!o_out.valid && i_in.ready))
        else $error("output continued after the last digit");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input accepted while digits are pending");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import rdc_pkg::*;
();

    localparam int unsigned VALUE_BITS    = 64;
    localparam int unsigned MAX_DIGITS    = 64;
    localparam int          QUIET_LIMIT   = 20000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          END_CYCLES    = 200;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          RAND_PHASES   = 7;
    localparam int          PHASE_ITEMS   = 17;

    localparam logic [63:0] VALUE_MASK =
        (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
    localparam int DIGIT_LIMIT = (MAX_DIGITS > 64) ? 64 : ((MAX_DIGITS == 0) ? 1 : MAX_DIGITS);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_digit;

    class digit_scoreboard;
        logic [RADIX_W-1:0] radix_reg;
        t_digit             expected_digits[$];
        int                 mismatches;
        int                 values_seen;
        int                 digits_checked;

        function new();
            radix_reg      = RADIX_RESET;
            mismatches     = 0;
            values_seen    = 0;
            digits_checked = 0;
        endfunction

        function void write_radix(input logic [RADIX_W-1:0] r);
            radix_reg = r;
        endfunction

        function int pending_count();
            return expected_digits.size();
        endfunction

        function void note_value(input logic [63:0] v);
            logic [63:0]        quot;
            logic [63:0]        base;
            logic [DIGIT_W-1:0] rem_store [0:63];
            logic [DIGIT_W-1:0] rem;
            t_digit             d;
            int                 n;
            if (radix_reg < RADIX_MIN) begin
                base = 64'(RADIX_MIN);
            end else if (radix_reg > RADIX_MAX) begin
                base = 64'(RADIX_MAX);
            end else begin
                base = 64'(radix_reg);
            end
            quot = v & VALUE_MASK;
            n = 0;
            do begin
                rem_store[n] = DIGIT_W'(quot % base);
                quot = quot / base;
                n++;
            end while (quot != 64'd0 && n < DIGIT_LIMIT);
            for (int k = n - 1; k >= 0; k--) begin
                rem = rem_store[k];
                if (rem >= DEC_DIGITS) begin
                    d.ch = ASCII_A + CHAR_W'(rem - DEC_DIGITS);
                end else begin
                    d.ch = ASCII_ZERO + CHAR_W'(rem);
                end
                d.last = (k == 0);
                expected_digits.push_back(d);
            end
            values_seen++;
        endfunction

        function void check_digit(input logic [CHAR_W-1:0] ch, input logic last);
            t_digit d;
            if (expected_digits.size() == 0) begin
                $display("%0t: unexpected digit: expected none, actual char %h last %b",
                         $time, ch, last);
                mismatches++;
            end else begin
                d = expected_digits.pop_front();
                if (ch !== d.ch || last !== d.last) begin
                    $display("%0t: digit mismatch: expected char %h last %b, actual char %h last %b",
                             $time, d.ch, d.last, ch, last);
                    mismatches++;
                end
                digits_checked++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [RADIX_W-1:0] i_cfg_wdata;

    rdc_in_if  in_ch ();
    rdc_out_if out_ch ();

    radix_digit_converter_core #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    digit_scoreboard sb;
    int              snd_idle;
    int              rcv_stall;
    int              hold_left;
    int              quiet_cycles;
    int              radix_writes;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // output side: check each transfer, then choose ready for the next cycle
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_digit(out_ch.digit_char, out_ch.last_digit);
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_stall);
            end
        end
    end

    task automatic send_value(input logic [63:0] v);
        while ($urandom_range(99) < snd_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_value(v);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic change_radix(input logic [RADIX_W-1:0] r);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_radix(r);
        radix_writes++;
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          sel;
        v   = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 25) begin
            v = v >> $urandom_range(63);
        end else if (sel < 40) begin
            v = 64'($urandom_range(1000));
        end else if (sel < 45) begin
            v = ($urandom_range(1) == 1) ? {64{1'b1}} : 64'd0;
        end
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] phase_radix(input int p);
        logic [RADIX_W-1:0] r;
        case (p)
            0: r = RADIX_W'(10);
            1: r = RADIX_W'(16);
            2: r = RADIX_W'(2);
            3: r = RADIX_W'(36);
            5: r = RADIX_W'(7);
            default: r = RADIX_W'($urandom_range(63));
        endcase
        return r;
    endfunction

    initial begin
        sb           = new();
        snd_idle     = 0;
        rcv_stall    = 0;
        hold_left    = 0;
        radix_writes = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.value  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset radix, zero and the full range
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value({64{1'b1}});
        send_value(64'h8000_0000_0000_0000);
        send_value(64'd1234567890);
        // radix below two saturates to two
        change_radix(RADIX_W'(0));
        send_value(64'd0);
        send_value(64'd5);
        send_value({64{1'b1}});
        change_radix(RADIX_W'(1));
        send_value(64'd3);
        change_radix(RADIX_W'(36));
        send_value(64'd35);
        send_value(64'd36);
        send_value({64{1'b1}});
        // radix above thirty-six saturates to thirty-six
        change_radix(RADIX_W'(63));
        send_value(64'd35);
        send_value({64{1'b1}});
        change_radix(RADIX_W'(37));
        send_value(64'd1295);
        change_radix(RADIX_W'(16));
        send_value(64'hFEDC_BA98_7654_3210);
        send_value(64'hF);

        for (int p = 0; p < RAND_PHASES; p++) begin
            change_radix(phase_radix(p));
            case (p % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 48; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 48; end
                default: begin snd_idle = 15; rcv_stall = 15; end
            endcase
            if (p == 1) begin
                hold_left = HOLD_CYCLES;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_value(pick_value());
            end
        end

        snd_idle  = 0;
        rcv_stall = 0;
        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("run covered %0d values and %0d digits across %0d radix writes,",
                 sb.values_seen, sb.digits_checked, radix_writes);
        $display("with sender gaps, output stalls, a long output hold-off and a full drain");
        if (sb.pending_count() != 0) begin
            $display("%0t: %0d expected digits never arrived", $time, sb.pending_count());
        end
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
